@@ rtl/lswd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lswd_pkg: shared types and constants of the scan width detector
// Sizes, codes, sequencer states and the quarter-wave sine table builder.
// ----------------------------------------------------------------------------
package lswd_pkg;

  localparam int MAX_SAMPLES = 2048;
  localparam int CNT_W       = $clog2(MAX_SAMPLES);
  localparam int TRIG_BITS   = 10;
  localparam int TRIG_N      = 1 << TRIG_BITS;
  localparam int ANG_SHIFT   = 14 - TRIG_BITS;

  localparam int RANGE_W = 16;
  localparam int POS_W   = 17;
  localparam int MUL_W   = 18;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;

  localparam logic [15:0] SINE_FULL   = 16'd32767;
  localparam logic [15:0] QUARTER_ANG = 16'h4000;

  typedef longint unsigned u64_t;
  localparam u64_t HALF_PI_Q30 = 64'd1686629713;

  typedef logic [15:0] trig_tab_t [TRIG_N];

  typedef enum logic [1:0] {
    STAT_NONE  = 2'd0,
    STAT_MATCH = 2'd1,
    STAT_LONE  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_JUMP_LIMIT  = 3'd0,
    REG_MIN_WIDTH   = 3'd1,
    REG_MAX_WIDTH   = 3'd2,
    REG_START_ANGLE = 3'd3,
    REG_ANGLE_STEP  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] jump_limit;
    logic [15:0] min_width;
    logic [15:0] max_width;
    logic [15:0] start_angle;
    logic [15:0] angle_step;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ANG_MUL,
    ST_ANG_SUM,
    ST_COS_RD,
    ST_COS_MUL,
    ST_COS_WR,
    ST_SIN_RD,
    ST_SIN_MUL,
    ST_SIN_WR,
    ST_UPD,
    ST_NEW,
    ST_NONE,
    ST_CL_DX,
    ST_CL_DY,
    ST_CL_LO,
    ST_CL_HI,
    ST_CL_DEC,
    ST_EMIT
  } state_t;

  // Taylor series to x^13 in Q30, rounded to Q15; evaluated at elaboration.
  function automatic trig_tab_t trig_build();
    trig_tab_t t;
    u64_t      x;
    u64_t      x2;
    u64_t      term;
    longint    sum;
    longint    r;
    for (int k = 0; k < TRIG_N; k++) begin
      x    = (u64_t'(k) * HALF_PI_Q30) >> TRIG_BITS;
      x2   = (x * x) >> 30;
      sum  = longint'(x);
      term = ((x * x2) >> 30) / 64'd6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + longint'(term);
      if (sum < 0) sum = 0;
      r = (sum + 16384) >>> 15;
      if (r > 32767) r = 32767;
      t[k] = r[15:0];
    end
    return t;
  endfunction

endpackage
`default_nettype wire

@@ rtl/lswd_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lswd_mul: shared signed multiplier
// One 18x18 signed product per cycle, registered.
// ----------------------------------------------------------------------------
module lswd_mul (
  input  wire logic                                clk,
  input  wire logic signed [lswd_pkg::MUL_W-1:0]   mul_a,
  input  wire logic signed [lswd_pkg::MUL_W-1:0]   mul_b,
  output logic signed      [lswd_pkg::PROD_W-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule
`default_nettype wire

@@ rtl/lswd_trig_rom.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lswd_trig_rom: quarter-wave sine table
// Q1.15 entries, one registered read per cycle.
// ----------------------------------------------------------------------------
module lswd_trig_rom (
  input  wire logic                            clk,
  input  wire logic [lswd_pkg::TRIG_BITS-1:0]  rd_addr,
  output logic      [15:0]                     rd_data_r
);

  localparam lswd_pkg::trig_tab_t TAB = lswd_pkg::trig_build();

  always_ff @(posedge clk) begin
    rd_data_r <= TAB[rd_addr];
  end

endmodule
`default_nettype wire

@@ rtl/lswd_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lswd_core: sample sequencer and run tracker
// Polar to Cartesian, run break detection, chord test and result register,
// all through one shared multiplier and the sine table.
// ----------------------------------------------------------------------------
module lswd_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire lswd_pkg::cfg_t                      cfg,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [lswd_pkg::RANGE_W-1:0]        in_range,
  input  wire logic                                in_no_return,
  input  wire logic                                in_last,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output lswd_pkg::status_t                        out_status,
  output logic signed [lswd_pkg::POS_W-1:0]        out_pos_x,
  output logic signed [lswd_pkg::POS_W-1:0]        out_pos_y
);

  localparam int PW = lswd_pkg::POS_W;
  localparam int MW = lswd_pkg::MUL_W;
  localparam int TB = lswd_pkg::TRIG_BITS;

  lswd_pkg::state_t state_r, state_nxt;
  lswd_pkg::state_t ret_r;

  logic [lswd_pkg::RANGE_W-1:0] range_r;
  logic                         none_r;
  logic                         last_r;
  logic [lswd_pkg::CNT_W-1:0]   cnt_r;
  logic [lswd_pkg::RANGE_W-1:0] prev_range_r;
  logic                         prev_had_r;
  logic [1:0]                   run_len_r;
  logic signed [PW-1:0]         sx_r, sy_r, ex_r, ey_r;
  logic signed [PW-1:0]         mx_r, my_r, lx_r, ly_r;
  logic                         match_valid_r, lone_valid_r;
  logic signed [PW-1:0]         x_r, y_r;
  logic [15:0]                  ang_r;
  logic                         neg_r, full_r;
  logic [PW+18:0]               acc_r;
  logic                         ge_r;

  logic                         out_valid_r;
  lswd_pkg::status_t            out_status_r;
  logic signed [PW-1:0]         out_x_r, out_y_r;

  logic signed [MW-1:0]                 mul_a, mul_b;
  logic signed [lswd_pkg::PROD_W-1:0]   prod_r;
  logic [TB-1:0]                        rom_addr;
  logic [15:0]                          rom_q;

  logic [15:0]          ang_sel;
  logic [TB-1:0]        ang_j;
  logic                 ang_full;
  logic [15:0]          sine_mag;
  logic signed [MW-1:0] sine_s;
  logic signed [MW-1:0] dx, dy, sumx, sumy;
  logic [lswd_pkg::RANGE_W-1:0] diff;
  logic                 join_run;
  logic                 out_load;
  logic                 chord_ok;

  lswd_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  lswd_trig_rom u_rom (
    .clk       (clk),
    .rd_addr   (rom_addr),
    .rd_data_r (rom_q)
  );

  // table address: quadrant 1 and 3 mirror the index
  assign ang_sel  = (state_r == lswd_pkg::ST_COS_RD) ? ang_r + lswd_pkg::QUARTER_ANG : ang_r;
  assign ang_j    = ang_sel[13:lswd_pkg::ANG_SHIFT];
  assign ang_full = ang_sel[14] && (ang_j == '0);
  assign rom_addr = ang_sel[14] ? TB'('0 - ang_j) : ang_j;

  assign sine_mag = full_r ? lswd_pkg::SINE_FULL : rom_q;
  assign sine_s   = neg_r ? -$signed({2'b00, sine_mag}) : $signed({2'b00, sine_mag});

  assign dx   = {sx_r[PW-1], sx_r} - {ex_r[PW-1], ex_r};
  assign dy   = {sy_r[PW-1], sy_r} - {ey_r[PW-1], ey_r};
  assign sumx = {sx_r[PW-1], sx_r} + {ex_r[PW-1], ex_r};
  assign sumy = {sy_r[PW-1], sy_r} + {ey_r[PW-1], ey_r};

  assign diff     = (range_r > prev_range_r) ? range_r - prev_range_r : prev_range_r - range_r;
  assign join_run = prev_had_r && (run_len_r != 2'd0) && (diff <= cfg.jump_limit);
  assign chord_ok = ge_r && (acc_r < $unsigned(prod_r));

  assign out_load = (state_r == lswd_pkg::ST_EMIT) && (!out_valid_r || out_tready);

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      lswd_pkg::ST_ANG_MUL: begin
        mul_a = MW'(cfg.angle_step);
        mul_b = MW'(cnt_r);
      end
      lswd_pkg::ST_COS_MUL, lswd_pkg::ST_SIN_MUL: begin
        mul_a = MW'(range_r);
        mul_b = sine_s;
      end
      lswd_pkg::ST_CL_DX: begin
        mul_a = dx;
        mul_b = dx;
      end
      lswd_pkg::ST_CL_DY: begin
        mul_a = dy;
        mul_b = dy;
      end
      lswd_pkg::ST_CL_LO: begin
        mul_a = MW'(cfg.min_width);
        mul_b = MW'(cfg.min_width);
      end
      lswd_pkg::ST_CL_HI: begin
        mul_a = MW'(cfg.max_width);
        mul_b = MW'(cfg.max_width);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lswd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // the closing pass returns to ret_r
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    case (state_r)
      lswd_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = in_no_return ? lswd_pkg::ST_CL_DX : lswd_pkg::ST_ANG_MUL;
        end
      end
      lswd_pkg::ST_ANG_MUL: state_nxt = lswd_pkg::ST_ANG_SUM;
      lswd_pkg::ST_ANG_SUM: state_nxt = lswd_pkg::ST_COS_RD;
      lswd_pkg::ST_COS_RD:  state_nxt = lswd_pkg::ST_COS_MUL;
      lswd_pkg::ST_COS_MUL: state_nxt = lswd_pkg::ST_COS_WR;
      lswd_pkg::ST_COS_WR:  state_nxt = lswd_pkg::ST_SIN_RD;
      lswd_pkg::ST_SIN_RD:  state_nxt = lswd_pkg::ST_SIN_MUL;
      lswd_pkg::ST_SIN_MUL: state_nxt = lswd_pkg::ST_SIN_WR;
      lswd_pkg::ST_SIN_WR:  state_nxt = lswd_pkg::ST_UPD;
      lswd_pkg::ST_UPD: begin
        if (!join_run) begin
          state_nxt = lswd_pkg::ST_CL_DX;
        end else begin
          state_nxt = last_r ? lswd_pkg::ST_CL_DX : lswd_pkg::ST_IDLE;
        end
      end
      lswd_pkg::ST_NEW, lswd_pkg::ST_NONE: begin
        state_nxt = last_r ? lswd_pkg::ST_CL_DX : lswd_pkg::ST_IDLE;
      end
      lswd_pkg::ST_CL_DX: begin
        state_nxt = (run_len_r == 2'd2) ? lswd_pkg::ST_CL_DY : ret_r;
      end
      lswd_pkg::ST_CL_DY:  state_nxt = lswd_pkg::ST_CL_LO;
      lswd_pkg::ST_CL_LO:  state_nxt = lswd_pkg::ST_CL_HI;
      lswd_pkg::ST_CL_HI:  state_nxt = lswd_pkg::ST_CL_DEC;
      lswd_pkg::ST_CL_DEC: state_nxt = ret_r;
      lswd_pkg::ST_EMIT: begin
        if (out_load) begin
          state_nxt = lswd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lswd_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ret_r         <= lswd_pkg::ST_IDLE;
      cnt_r         <= '0;
      prev_had_r    <= 1'b0;
      run_len_r     <= 2'd0;
      match_valid_r <= 1'b0;
      lone_valid_r  <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        lswd_pkg::ST_IDLE: begin
          if (in_tvalid && in_no_return) begin
            ret_r <= lswd_pkg::ST_NONE;
          end
        end
        lswd_pkg::ST_UPD: begin
          if (!join_run) begin
            ret_r <= lswd_pkg::ST_NEW;
          end else begin
            prev_had_r <= 1'b1;
            if (run_len_r != 2'd2) run_len_r <= run_len_r + 2'd1;
            cnt_r <= (cnt_r == lswd_pkg::CNT_W'(lswd_pkg::MAX_SAMPLES - 1)) ? '0 : cnt_r + 1'b1;
            ret_r <= lswd_pkg::ST_EMIT;
          end
        end
        lswd_pkg::ST_NEW, lswd_pkg::ST_NONE: begin
          prev_had_r <= (state_r == lswd_pkg::ST_NEW);
          run_len_r  <= (state_r == lswd_pkg::ST_NEW) ? 2'd1 : 2'd0;
          cnt_r <= (cnt_r == lswd_pkg::CNT_W'(lswd_pkg::MAX_SAMPLES - 1)) ? '0 : cnt_r + 1'b1;
          ret_r <= lswd_pkg::ST_EMIT;
        end
        lswd_pkg::ST_CL_DX: begin
          if (run_len_r != 2'd2) begin
            if (run_len_r == 2'd1) lone_valid_r <= 1'b1;
            run_len_r <= 2'd0;
          end
        end
        lswd_pkg::ST_CL_DEC: begin
          if (chord_ok) match_valid_r <= 1'b1;
          run_len_r <= 2'd0;
        end
        lswd_pkg::ST_EMIT: begin
          if (out_load) begin
            out_valid_r   <= 1'b1;
            cnt_r         <= '0;
            prev_had_r    <= 1'b0;
            run_len_r     <= 2'd0;
            match_valid_r <= 1'b0;
            lone_valid_r  <= 1'b0;
            ret_r         <= lswd_pkg::ST_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      lswd_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          range_r <= in_range;
          none_r  <= in_no_return;
          last_r  <= in_last;
        end
      end
      lswd_pkg::ST_ANG_SUM: ang_r <= cfg.start_angle + prod_r[15:0];
      lswd_pkg::ST_COS_RD, lswd_pkg::ST_SIN_RD: begin
        neg_r  <= ang_sel[15];
        full_r <= ang_full;
      end
      lswd_pkg::ST_COS_WR: x_r <= prod_r[PW+14:15];
      lswd_pkg::ST_SIN_WR: y_r <= prod_r[PW+14:15];
      lswd_pkg::ST_UPD: begin
        if (join_run) begin
          ex_r         <= x_r;
          ey_r         <= y_r;
          prev_range_r <= range_r;
        end
      end
      lswd_pkg::ST_NEW: begin
        sx_r         <= x_r;
        sy_r         <= y_r;
        ex_r         <= x_r;
        ey_r         <= y_r;
        prev_range_r <= range_r;
      end
      lswd_pkg::ST_CL_DX: begin
        if (run_len_r == 2'd1 && !lone_valid_r) begin
          lx_r <= sx_r;
          ly_r <= sy_r;
        end
      end
      lswd_pkg::ST_CL_DY: acc_r <= $unsigned(prod_r);
      lswd_pkg::ST_CL_LO: acc_r <= acc_r + $unsigned(prod_r);
      lswd_pkg::ST_CL_HI: ge_r  <= (acc_r >= $unsigned(prod_r));
      lswd_pkg::ST_CL_DEC: begin
        if (chord_ok) begin
          mx_r <= sumx[MW-1:1];
          my_r <= sumy[MW-1:1];
        end
      end
      lswd_pkg::ST_EMIT: begin
        if (out_load) begin
          if (match_valid_r) begin
            out_status_r <= lswd_pkg::STAT_MATCH;
            out_x_r      <= mx_r;
            out_y_r      <= my_r;
          end else if (lone_valid_r) begin
            out_status_r <= lswd_pkg::STAT_LONE;
            out_x_r      <= lx_r;
            out_y_r      <= ly_r;
          end else begin
            out_status_r <= lswd_pkg::STAT_NONE;
            out_x_r      <= '0;
            out_y_r      <= '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_status = out_status_r;
  assign out_pos_x  = out_x_r;
  assign out_pos_y  = out_y_r;

  // a no-return word closes the run and never touches the angle path
  a_none_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lswd_pkg::ST_NONE) |-> (none_r && run_len_r == 2'd0))
    else $error("no-return word reached bookkeeping with an open run");

  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    run_len_r != 2'd3)
    else $error("run length beyond saturation");

  a_scan_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (!match_valid_r && !lone_valid_r && cnt_r == '0 && out_valid_r))
    else $error("scan state not cleared after result");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == lswd_pkg::STAT_NONE) |-> (out_x_r == '0 && out_y_r == '0))
    else $error("empty result carries a position");

endmodule
`default_nettype wire

@@ rtl/lidar_segment_width_detector_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_segment_width_detector_top: scan breakpoint clustering with width test
// Splits a lidar scan into runs, tests each run's chord against a width window
// and reports the midpoint of the last match, else the first lone point.
// ----------------------------------------------------------------------------
//
//  port group | dir | width           | contents
//  -----------+-----+-----------------+-------------------------------------
//  in_*       | in  | tdata 16, user 1| one scan sample; tlast = last sample
//  out_*      | out | tdata 40, user 2| one result word per scan
//  cfg_*      | in  | APB, 32-bit data| five 16-bit registers at 0x00..0x10
//
//  A sample with a return runs the angle, cosine and sine steps, then either
//  extends the run or closes it (with the chord test for two or more points)
//  and starts a new one; a no-return sample goes straight to the closing pass.
//  The last sample adds the closing pass and the result step.
//  All products go through one shared 18x18 multiplier;
//  the sine table is a registered ROM read once for cosine, once for sine.
//  rst_n is synchronous; registers return to their defaults and scan state
//  clears. A stalled result holds in the output register; the next sample
//  is still taken, and a second result waits until the first one leaves.
//
module lidar_segment_width_detector_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [15:0]                       in_tdata,  // [15:0] range
  input  wire logic                              in_tuser,  // [0] no_return
  input  wire logic                              in_tlast,  // last_sample
  // result stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [39:0]                            out_tdata, // [16:0] pos_x, [33:17] pos_y
  output logic [1:0]                             out_tuser, // [1:0] status
  // configuration
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [lswd_pkg::CFG_AW-1:0]       cfg_paddr,
  input  wire logic [lswd_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [lswd_pkg::CFG_DW-1:0]            cfg_prdata,
  output logic                                   cfg_pready
);

  lswd_pkg::cfg_t cfg_r;
  logic           cfg_wr;
  logic [2:0]     reg_sel;

  lswd_pkg::status_t                     res_status;
  logic signed [lswd_pkg::POS_W-1:0]     res_x, res_y;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[4:2];

  // register file: write on the APB access phase, unknown addresses ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.jump_limit  <= 16'd307;
      cfg_r.min_width   <= 16'd20;
      cfg_r.max_width   <= 16'd82;
      cfg_r.start_angle <= 16'd0;
      cfg_r.angle_step  <= 16'd16;
    end else if (cfg_wr) begin
      case (reg_sel)
        lswd_pkg::REG_JUMP_LIMIT:  cfg_r.jump_limit  <= cfg_pwdata[15:0];
        lswd_pkg::REG_MIN_WIDTH:   cfg_r.min_width   <= cfg_pwdata[15:0];
        lswd_pkg::REG_MAX_WIDTH:   cfg_r.max_width   <= cfg_pwdata[15:0];
        lswd_pkg::REG_START_ANGLE: cfg_r.start_angle <= cfg_pwdata[15:0];
        lswd_pkg::REG_ANGLE_STEP:  cfg_r.angle_step  <= cfg_pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      lswd_pkg::REG_JUMP_LIMIT:  cfg_prdata = {16'd0, cfg_r.jump_limit};
      lswd_pkg::REG_MIN_WIDTH:   cfg_prdata = {16'd0, cfg_r.min_width};
      lswd_pkg::REG_MAX_WIDTH:   cfg_prdata = {16'd0, cfg_r.max_width};
      lswd_pkg::REG_START_ANGLE: cfg_prdata = {16'd0, cfg_r.start_angle};
      lswd_pkg::REG_ANGLE_STEP:  cfg_prdata = {16'd0, cfg_r.angle_step};
      default:                   cfg_prdata = '0;
    endcase
  end

  lswd_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_range     (in_tdata),
    .in_no_return (in_tuser),
    .in_last      (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_status   (res_status),
    .out_pos_x    (res_x),
    .out_pos_y    (res_y)
  );

  // pack the result word, padded to whole bytes
  assign out_tdata = {6'd0, res_y, res_x};
  assign out_tuser = res_status;

endmodule
`default_nettype wire
